[design/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros
// Shared assertion macros. Each expects aclk and aresetn in scope.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition holds at every edge out of reset
`define ASSERT_ALWAYS(lbl, expr, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) \
        else $error(msg);

// Same-cycle implication
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

[design/fps_pkg.sv]
// ----------------------------------------------------------------------------
// fps_pkg
// Types, codes and reset values shared by the flight phase sequencer.
// ----------------------------------------------------------------------------
package fps_pkg;

    localparam int unsigned CNT_W      = 16;
    localparam int unsigned PHASE_W    = 4;
    localparam int unsigned ACT_W      = 3;
    localparam int unsigned TGT_W      = 2;
    localparam int unsigned DRV_W      = 3;
    localparam int unsigned REG_IDX_W  = 3;
    localparam int unsigned APB_ADDR_W = 5;
    localparam int unsigned APB_DATA_W = 32;

    typedef logic [CNT_W-1:0]     cnt_t;
    typedef logic [PHASE_W-1:0]   phase_t;
    typedef logic [ACT_W-1:0]     action_t;
    typedef logic [TGT_W-1:0]     target_t;
    typedef logic [DRV_W-1:0]     drive_t;
    typedef logic [REG_IDX_W-1:0] reg_idx_t;

    localparam cnt_t CNT_ONE = 16'd1;

    // flight phases
    localparam phase_t PH_PREFLIGHT  = 4'd0;
    localparam phase_t PH_ASCENDING  = 4'd1;
    localparam phase_t PH_FLOATING   = 4'd2;
    localparam phase_t PH_MEAS1      = 4'd3;
    localparam phase_t PH_BURNWIRE   = 4'd4;
    localparam phase_t PH_INFLATING  = 4'd5;
    localparam phase_t PH_MEAS2      = 4'd6;
    localparam phase_t PH_CURING     = 4'd7;
    localparam phase_t PH_EQUALIZING = 4'd8;
    localparam phase_t PH_MEAS3      = 4'd9;
    localparam phase_t PH_DESCENDING = 4'd10;

    // input word kinds
    localparam action_t ACT_TICK   = 3'd0;
    localparam action_t ACT_LAUNCH = 3'd1;
    localparam action_t ACT_ACCEPT = 3'd2;
    localparam action_t ACT_CANCEL = 3'd3;
    localparam action_t ACT_MANUAL = 3'd4;

    // manual write targets
    localparam target_t TGT_TANK   = 2'd0;
    localparam target_t TGT_OUTLET = 2'd1;
    localparam target_t TGT_BURN   = 2'd2;

    // bit positions in the drive vector
    localparam int unsigned DRV_TANK   = 0;
    localparam int unsigned DRV_OUTLET = 1;
    localparam int unsigned DRV_BURN   = 2;

    localparam logic ANN_INFLATE = 1'b0;
    localparam logic ANN_DEFLATE = 1'b1;

    // register map
    localparam reg_idx_t REG_ASCEND   = 3'd0;
    localparam reg_idx_t REG_BURNWIRE = 3'd1;
    localparam reg_idx_t REG_INFLATE  = 3'd2;
    localparam reg_idx_t REG_CURE     = 3'd3;
    localparam reg_idx_t REG_EQUALIZE = 3'd4;
    localparam reg_idx_t REG_ANNOUNCE = 3'd5;

    localparam cnt_t RST_ASCEND   = 16'd100;
    localparam cnt_t RST_BURNWIRE = 16'd30;
    localparam cnt_t RST_INFLATE  = 16'd57;
    localparam cnt_t RST_CURE     = 16'd60;
    localparam cnt_t RST_EQUALIZE = 16'd30;
    localparam cnt_t RST_ANNOUNCE = 16'd30;

    typedef struct packed {
        cnt_t ascend_seconds;
        cnt_t burnwire_seconds;
        cnt_t inflate_seconds;
        cnt_t cure_seconds;
        cnt_t equalize_seconds;
        cnt_t announce_seconds;
    } cfg_t;

    typedef struct packed {
        action_t action;
        target_t actuator;
        logic    level;
    } item_t;

    typedef struct packed {
        phase_t phase;
        logic   tank_open;
        logic   outlet_open;
        logic   burnwire_on;
        logic   announce_request;
        logic   announce_kind;
        logic   phase_changed;
    } result_t;

endpackage

[design/fps_apb_regs.sv]
// ----------------------------------------------------------------------------
// fps_apb_regs
// APB register file holding the phase and announce timeouts.
// ----------------------------------------------------------------------------
module fps_apb_regs
    import fps_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output cfg_t                  cfg
);

    cfg_t     cfg_reg;
    cfg_t     cfg_next;
    reg_idx_t idx;
    cnt_t     wval;
    cnt_t     rval;

    assign pready = 1'b1;
    assign idx    = paddr[APB_ADDR_W-1:2];
    assign wval   = pwdata[CNT_W-1:0];

    always_comb begin
        cfg_next = cfg_reg;
        if (psel && penable && pwrite) begin
            unique case (idx)
                REG_ASCEND:   cfg_next.ascend_seconds   = wval;
                REG_BURNWIRE: cfg_next.burnwire_seconds = wval;
                REG_INFLATE:  cfg_next.inflate_seconds  = wval;
                REG_CURE:     cfg_next.cure_seconds     = wval;
                REG_EQUALIZE: cfg_next.equalize_seconds = wval;
                REG_ANNOUNCE: cfg_next.announce_seconds = wval;
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (idx)
            REG_ASCEND:   rval = cfg_reg.ascend_seconds;
            REG_BURNWIRE: rval = cfg_reg.burnwire_seconds;
            REG_INFLATE:  rval = cfg_reg.inflate_seconds;
            REG_CURE:     rval = cfg_reg.cure_seconds;
            REG_EQUALIZE: rval = cfg_reg.equalize_seconds;
            REG_ANNOUNCE: rval = cfg_reg.announce_seconds;
            default:      rval = '0;
        endcase
    end

    assign prdata = {{(APB_DATA_W-CNT_W){1'b0}}, rval};
    assign cfg    = cfg_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.ascend_seconds   <= RST_ASCEND;
            cfg_reg.burnwire_seconds <= RST_BURNWIRE;
            cfg_reg.inflate_seconds  <= RST_INFLATE;
            cfg_reg.cure_seconds     <= RST_CURE;
            cfg_reg.equalize_seconds <= RST_EQUALIZE;
            cfg_reg.announce_seconds <= RST_ANNOUNCE;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

[design/fps_seq_state.sv]
// ----------------------------------------------------------------------------
// fps_seq_state
// Phase, countdown and drive state with the single-pass update for one word.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module fps_seq_state
    import fps_pkg::*;
(
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    step_en,
    input  item_t   item,
    input  cfg_t    cfg,
    output result_t result
);

    typedef struct packed {
        phase_t phase;
        cnt_t   pcnt;
        logic   pact;
        cnt_t   acnt;
        logic   apend;
        drive_t drive;
    } seq_state_t;

    seq_state_t state_reg;
    seq_state_t state_next;

    logic   ann_fire;
    logic   tim_fire;
    logic   done;
    logic   tim_enter;
    phase_t tim_tgt;
    logic   done_enter;
    phase_t done_tgt;
    logic   enter_en;
    phase_t enter_tgt;
    logic   ann_req;
    logic   ann_kind;
    logic   changed;

    logic   ann_phase;
    logic   meas_phase;
    logic   timed_phase;
    logic   req_phase;

    // timer expiry map
    always_comb begin
        tim_enter = 1'b1;
        tim_tgt   = PH_PREFLIGHT;
        unique case (state_reg.phase)
            PH_ASCENDING:  tim_tgt = PH_FLOATING;
            PH_BURNWIRE:   tim_tgt = PH_INFLATING;
            PH_INFLATING:  tim_tgt = PH_MEAS2;
            PH_CURING:     tim_tgt = PH_EQUALIZING;
            PH_EQUALIZING: tim_tgt = PH_MEAS3;
            default:       tim_enter = 1'b0;
        endcase
    end

    // accept or announce timeout map
    always_comb begin
        done_enter = 1'b1;
        done_tgt   = PH_PREFLIGHT;
        unique case (state_reg.phase)
            PH_FLOATING: done_tgt = PH_BURNWIRE;
            PH_CURING:   done_tgt = PH_EQUALIZING;
            default:     done_enter = 1'b0;
        endcase
    end

    always_comb begin
        state_next = state_reg;
        ann_fire   = 1'b0;
        tim_fire   = 1'b0;
        done       = 1'b0;
        enter_en   = 1'b0;
        enter_tgt  = PH_PREFLIGHT;
        ann_req    = 1'b0;
        ann_kind   = ANN_INFLATE;
        changed    = 1'b0;

        unique case (item.action)
            ACT_TICK: begin
                if (state_reg.apend) begin
                    if (state_reg.acnt <= CNT_ONE) begin
                        ann_fire = 1'b1;
                    end else begin
                        state_next.acnt = state_reg.acnt - CNT_ONE;
                    end
                end
                if (state_reg.pact) begin
                    if (state_reg.pcnt <= CNT_ONE) begin
                        tim_fire = 1'b1;
                    end else begin
                        state_next.pcnt = state_reg.pcnt - CNT_ONE;
                    end
                end
                done = ann_fire;
                // announce wins a tie; the phase it enters restarts the timer
                if (!ann_fire && tim_fire) begin
                    state_next.pact = 1'b0;
                    state_next.pcnt = '0;
                    enter_en        = tim_enter;
                    enter_tgt       = tim_tgt;
                end
            end
            ACT_LAUNCH: begin
                enter_en  = 1'b1;
                enter_tgt = PH_ASCENDING;
            end
            ACT_ACCEPT: begin
                done = state_reg.apend;
            end
            ACT_MANUAL: begin
                unique case (item.actuator)
                    TGT_TANK:   state_next.drive[DRV_TANK]   = item.level;
                    TGT_OUTLET: state_next.drive[DRV_OUTLET] = item.level;
                    TGT_BURN:   state_next.drive[DRV_BURN]   = item.level;
                    default: ;
                endcase
            end
            default: ;
        endcase

        if (done) begin
            state_next.apend = 1'b0;
            state_next.acnt  = '0;
            enter_en         = done_enter;
            enter_tgt        = done_tgt;
        end

        if (enter_en) begin
            // entering a phase stops the timer and drops any pending announce
            state_next.pact  = 1'b0;
            state_next.pcnt  = '0;
            state_next.apend = 1'b0;
            state_next.acnt  = '0;
            state_next.phase = enter_tgt;
            changed          = (enter_tgt != state_reg.phase);
            unique case (enter_tgt)
                PH_ASCENDING: begin
                    state_next.drive[DRV_OUTLET] = 1'b1;
                    state_next.pact = 1'b1;
                    state_next.pcnt = cfg.ascend_seconds;
                end
                PH_FLOATING: begin
                    state_next.drive[DRV_OUTLET] = 1'b1;
                    state_next.apend = 1'b1;
                    state_next.acnt  = cfg.announce_seconds;
                    ann_req  = 1'b1;
                    ann_kind = ANN_INFLATE;
                end
                PH_BURNWIRE: begin
                    state_next.drive[DRV_BURN] = 1'b1;
                    state_next.pact = 1'b1;
                    state_next.pcnt = cfg.burnwire_seconds;
                end
                PH_INFLATING: begin
                    state_next.drive[DRV_BURN]   = 1'b0;
                    state_next.drive[DRV_OUTLET] = 1'b0;
                    state_next.drive[DRV_TANK]   = 1'b1;
                    state_next.pact = 1'b1;
                    state_next.pcnt = cfg.inflate_seconds;
                end
                PH_MEAS2: begin
                    // measure passes at once: go straight on to curing
                    state_next.drive[DRV_OUTLET] = 1'b0;
                    state_next.drive[DRV_TANK]   = 1'b1;
                    state_next.pact  = 1'b1;
                    state_next.pcnt  = cfg.cure_seconds;
                    state_next.apend = 1'b1;
                    state_next.acnt  = cfg.announce_seconds;
                    state_next.phase = PH_CURING;
                    ann_req  = 1'b1;
                    ann_kind = ANN_DEFLATE;
                    changed  = 1'b1;
                end
                PH_EQUALIZING: begin
                    state_next.drive[DRV_TANK]   = 1'b0;
                    state_next.drive[DRV_OUTLET] = 1'b1;
                    state_next.pact = 1'b1;
                    state_next.pcnt = cfg.equalize_seconds;
                end
                PH_MEAS3: begin
                    // measure passes at once: go straight on to descending
                    state_next.drive[DRV_TANK]   = 1'b0;
                    state_next.drive[DRV_OUTLET] = 1'b1;
                    state_next.phase = PH_DESCENDING;
                    changed = 1'b1;
                end
                default: ;
            endcase
        end
    end

    assign result.phase            = state_next.phase;
    assign result.tank_open        = state_next.drive[DRV_TANK];
    assign result.outlet_open      = state_next.drive[DRV_OUTLET];
    assign result.burnwire_on      = state_next.drive[DRV_BURN];
    assign result.announce_request = ann_req;
    assign result.announce_kind    = ann_kind;
    assign result.phase_changed    = changed;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg.phase <= PH_PREFLIGHT;
            state_reg.pcnt  <= '0;
            state_reg.pact  <= 1'b0;
            state_reg.acnt  <= '0;
            state_reg.apend <= 1'b0;
            state_reg.drive <= '0;
        end else if (step_en) begin
            state_reg <= state_next;
        end
    end

    assign ann_phase   = (state_reg.phase == PH_FLOATING) || (state_reg.phase == PH_CURING);
    assign meas_phase  = (state_reg.phase == PH_MEAS1) || (state_reg.phase == PH_MEAS2) ||
                         (state_reg.phase == PH_MEAS3);
    assign timed_phase = (state_reg.phase == PH_ASCENDING) || (state_reg.phase == PH_BURNWIRE) ||
                         (state_reg.phase == PH_INFLATING) || (state_reg.phase == PH_CURING) ||
                         (state_reg.phase == PH_EQUALIZING);
    assign req_phase   = (result.phase == PH_FLOATING) || (result.phase == PH_CURING);

    `ASSERT_IMPL(a_ann_phase, state_reg.apend, ann_phase, "announce pending outside floating or curing")
    `ASSERT_ALWAYS(a_no_meas, !meas_phase, "measuring phase held")
    `ASSERT_IMPL(a_timer_phase, state_reg.pact, timed_phase, "phase timer active in untimed phase")
    `ASSERT_NEXT(a_hold, !step_en, $stable(state_reg), "state moved without a step")
    `ASSERT_IMPL(a_req_phase, result.announce_request, req_phase, "announce sent outside floating or curing")

endmodule

[design/flight_phase_sequencer_core.sv]
// An accepted word waits in the input register and is stepped into the result register on m_tdata.
// Throughput: one word per cycle unless m_tready stalls; phase and countdowns update in one pass.
// A stalled result register holds the input register, and s_tready drops only when both are full.
// Reset: aresetn, synchronous, active low; sets phase to preflight, clears countdowns and drives,
// empties both registers and loads the timeout registers with their defaults.
// ----------------------------------------------------------------------------
// flight_phase_sequencer_core
// Mission sequencer: stream of ticks, launches, ground replies and manual writes in,
// phase, actuator drives and announce requests out, timeouts set over APB.
// ----------------------------------------------------------------------------
module flight_phase_sequencer_core
    import fps_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    // input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [1:0] actuator, [2] level
    input  logic [2:0]            s_tuser,   // [2:0] action
    // result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,   // [3:0] phase, [4] tank_open, [5] outlet_open,
                                             // [6] burnwire_on, [7] announce_request,
                                             // [8] announce_kind, [9] phase_changed
    // configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    logic    in_valid_reg;
    logic    in_valid_next;
    item_t   item_reg;
    logic    out_valid_reg;
    logic    out_valid_next;
    result_t result_reg;
    result_t step_result;
    cfg_t    cfg;
    logic    step_en;

    fps_apb_regs u_regs (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    fps_seq_state u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .step_en (step_en),
        .item    (item_reg),
        .cfg     (cfg),
        .result  (step_result)
    );

    // advance a held word whenever the result register is free or draining
    assign step_en  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step_en;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_tready) begin
            in_valid_next = s_tvalid;
        end
        out_valid_next = out_valid_reg;
        if (step_en) begin
            out_valid_next = 1'b1;
        end else if (m_tready) begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            item_reg.action   <= s_tuser;
            item_reg.actuator <= s_tdata[1:0];
            item_reg.level    <= s_tdata[2];
        end
        if (step_en) begin
            result_reg <= step_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {6'd0,
                       result_reg.phase_changed,
                       result_reg.announce_kind,
                       result_reg.announce_request,
                       result_reg.burnwire_on,
                       result_reg.outlet_open,
                       result_reg.tank_open,
                       result_reg.phase};

endmodule

[tb/fps_result_check.sv]
// ----------------------------------------------------------------------------
// fps_result_check
// Watches the word streams and the APB port of the flight phase sequencer,
// predicts every result from its own copy of the phase, the countdowns and
// the timeouts, and compares each result word field by field.
// ----------------------------------------------------------------------------
module fps_result_check
    import fps_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    input  logic                  s_tready,
    input  logic [7:0]            s_tdata,   // [1:0] actuator, [2] level
    input  logic [2:0]            s_tuser,   // [2:0] action
    input  logic                  m_tvalid,
    input  logic                  m_tready,
    input  logic [15:0]           m_tdata,   // [3:0] phase, [4] tank_open, [5] outlet_open,
                                             // [6] burnwire_on, [7] announce_request,
                                             // [8] announce_kind, [9] phase_changed
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    input  logic                  pready,
    output int                    mismatches,
    output int                    results_due,
    output int                    results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    result_t expected_words[$];

    cnt_t   timeouts [REG_ASCEND:REG_ANNOUNCE];
    phase_t cur_phase;
    cnt_t   phase_left;
    logic   phase_timing;
    cnt_t   reply_left;
    logic   reply_waiting;
    drive_t drives;

    logic   step_announce;
    logic   step_kind;
    logic   step_changed;

    task automatic report_mismatch(input string what);
        mismatches++;
        $display("[%0t] result word %0d: %s", $realtime, results_seen, what);
    endtask

    task automatic check_field(input string name, input logic [3:0] got, input logic [3:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s is %0h, expected %0h", name, got, want));
        end
    endtask

    task automatic check_bit(input string name, input logic got, input logic want);
        if (got !== want) begin
            report_mismatch($sformatf("%s is %0b, expected %0b", name, got, want));
        end
    endtask

    function automatic void reset_flight();
        timeouts[REG_ASCEND]   = RST_ASCEND;
        timeouts[REG_BURNWIRE] = RST_BURNWIRE;
        timeouts[REG_INFLATE]  = RST_INFLATE;
        timeouts[REG_CURE]     = RST_CURE;
        timeouts[REG_EQUALIZE] = RST_EQUALIZE;
        timeouts[REG_ANNOUNCE] = RST_ANNOUNCE;
        cur_phase     = PH_PREFLIGHT;
        phase_left    = '0;
        phase_timing  = 1'b0;
        reply_left    = '0;
        reply_waiting = 1'b0;
        drives        = '0;
    endfunction

    function automatic void start_phase_timer(input cnt_t ticks);
        phase_timing = 1'b1;
        phase_left   = ticks;
    endfunction

    function automatic void send_announce(input logic kind);
        reply_waiting = 1'b1;
        reply_left    = timeouts[REG_ANNOUNCE];
        step_announce = 1'b1;
        step_kind     = kind;
    endfunction

    // The second and third measuring phases fall straight through to the next one.
    function automatic void enter_flight_phase(input phase_t target);
        phase_t nxt;
        logic   more;
        nxt  = target;
        more = 1'b1;
        while (more) begin
            phase_timing  = 1'b0;
            phase_left    = '0;
            reply_waiting = 1'b0;
            reply_left    = '0;
            case (nxt)
                PH_ASCENDING: begin
                    drives[DRV_OUTLET] = 1'b1;
                    start_phase_timer(timeouts[REG_ASCEND]);
                end
                PH_FLOATING: begin
                    drives[DRV_OUTLET] = 1'b1;
                    send_announce(ANN_INFLATE);
                end
                PH_BURNWIRE: begin
                    drives[DRV_BURN] = 1'b1;
                    start_phase_timer(timeouts[REG_BURNWIRE]);
                end
                PH_INFLATING: begin
                    drives[DRV_BURN]   = 1'b0;
                    drives[DRV_OUTLET] = 1'b0;
                    drives[DRV_TANK]   = 1'b1;
                    start_phase_timer(timeouts[REG_INFLATE]);
                end
                PH_MEAS2: begin
                    drives[DRV_OUTLET] = 1'b0;
                    drives[DRV_TANK]   = 1'b1;
                end
                PH_CURING: begin
                    start_phase_timer(timeouts[REG_CURE]);
                    send_announce(ANN_DEFLATE);
                end
                PH_EQUALIZING, PH_MEAS3: begin
                    drives[DRV_TANK]   = 1'b0;
                    drives[DRV_OUTLET] = 1'b1;
                    if (nxt == PH_EQUALIZING) begin
                        start_phase_timer(timeouts[REG_EQUALIZE]);
                    end
                end
                default: begin
                end
            endcase
            if (nxt != cur_phase) begin
                cur_phase    = nxt;
                step_changed = 1'b1;
            end
            if (nxt == PH_MEAS2) begin
                nxt = PH_CURING;
            end else if (nxt == PH_MEAS3) begin
                nxt = PH_DESCENDING;
            end else begin
                more = 1'b0;
            end
        end
    endfunction

    function automatic void reply_finished();
        reply_waiting = 1'b0;
        reply_left    = '0;
        if (cur_phase == PH_FLOATING) begin
            enter_flight_phase(PH_BURNWIRE);
        end else if (cur_phase == PH_CURING) begin
            enter_flight_phase(PH_EQUALIZING);
        end
    endfunction

    function automatic void timer_finished();
        phase_timing = 1'b0;
        phase_left   = '0;
        case (cur_phase)
            PH_ASCENDING:  enter_flight_phase(PH_FLOATING);
            PH_BURNWIRE:   enter_flight_phase(PH_INFLATING);
            PH_INFLATING:  enter_flight_phase(PH_MEAS2);
            PH_CURING:     enter_flight_phase(PH_EQUALIZING);
            PH_EQUALIZING: enter_flight_phase(PH_MEAS3);
            default: begin
            end
        endcase
    endfunction

    // The announce wins when both countdowns run out on the same tick.
    function automatic void one_second();
        logic reply_due;
        logic timer_due;
        reply_due = 1'b0;
        timer_due = 1'b0;
        if (reply_waiting) begin
            if (reply_left <= CNT_ONE) reply_due = 1'b1;
            else reply_left = reply_left - CNT_ONE;
        end
        if (phase_timing) begin
            if (phase_left <= CNT_ONE) timer_due = 1'b1;
            else phase_left = phase_left - CNT_ONE;
        end
        if (reply_due) begin
            reply_finished();
        end else if (timer_due) begin
            timer_finished();
        end
    endfunction

    function automatic result_t predict_step(input action_t act, input target_t tgt,
                                             input logic lvl);
        result_t r;
        step_announce = 1'b0;
        step_kind     = 1'b0;
        step_changed  = 1'b0;
        case (act)
            ACT_TICK:   one_second();
            ACT_LAUNCH: enter_flight_phase(PH_ASCENDING);
            ACT_ACCEPT: begin
                if (reply_waiting) reply_finished();
            end
            ACT_MANUAL: begin
                case (tgt)
                    TGT_TANK:   drives[DRV_TANK]   = lvl;
                    TGT_OUTLET: drives[DRV_OUTLET] = lvl;
                    TGT_BURN:   drives[DRV_BURN]   = lvl;
                    default: begin
                    end
                endcase
            end
            // cancel and the unused codes leave everything as it is
            default: begin
            end
        endcase
        r.phase            = cur_phase;
        r.tank_open        = drives[DRV_TANK];
        r.outlet_open      = drives[DRV_OUTLET];
        r.burnwire_on      = drives[DRV_BURN];
        r.announce_request = step_announce;
        r.announce_kind    = step_announce & step_kind;
        r.phase_changed    = step_changed;
        return r;
    endfunction

    always @(posedge aclk) begin : watch
        result_t want;
        reg_idx_t idx;
        if (!aresetn) begin
            reset_flight();
            expected_words.delete();
        end else begin
            idx = reg_idx_t'(paddr >> 2);
            if (psel && penable && pwrite && pready && (paddr >> 2) <= REG_ANNOUNCE) begin
                timeouts[idx] = pwdata[CNT_W-1:0];
            end
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (expected_words.size() == 0) begin
                    report_mismatch("result word with no input word outstanding");
                end else begin
                    want = expected_words.pop_front();
                    check_field("phase", m_tdata[3:0], want.phase);
                    check_bit("tank_open", m_tdata[4], want.tank_open);
                    check_bit("outlet_open", m_tdata[5], want.outlet_open);
                    check_bit("burnwire_on", m_tdata[6], want.burnwire_on);
                    check_bit("announce_request", m_tdata[7], want.announce_request);
                    check_bit("announce_kind", m_tdata[8], want.announce_kind);
                    check_bit("phase_changed", m_tdata[9], want.phase_changed);
                    if (m_tdata[15:10] !== '0) begin
                        report_mismatch($sformatf("padding bits are %b", m_tdata[15:10]));
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                expected_words.push_back(predict_step(s_tuser, s_tdata[1:0], s_tdata[2]));
            end
        end
        results_due = expected_words.size();
    end

endmodule

[tb/tb.sv]
// ----------------------------------------------------------------------------
// tb
// Drives the flight phase sequencer with directed and random event words over
// several timeout settings and idling modes, and gives the verdict.
// ----------------------------------------------------------------------------
module tb
    import fps_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 60;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [7:0]            s_tdata  = '0;
    logic [2:0]            s_tuser  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [15:0]           m_tdata;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [APB_ADDR_W-1:0] paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int mismatches;
    int results_due;
    int results_seen;

    int send_idle_pct = 0;
    int stall_pct     = 0;
    int hold_asks     = 0;
    int hold_served   = 0;
    int hold_left     = 0;
    int quiet_cycles  = 0;
    int words_sent    = 0;
    int settings_used = 0;

    always #10 aclk = ~aclk;

    flight_phase_sequencer_core dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    fps_result_check u_result_check (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .mismatches   (mismatches),
        .results_due  (results_due),
        .results_seen (results_seen)
    );

    // Receiver: random stalls, or a long hold-off when one is asked for.
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left--;
            m_tready <= 1'b0;
        end else if (hold_served != hold_asks) begin
            hold_served++;
            hold_left = HOLD_CYCLES - 1;
            m_tready <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99) >= stall_pct);
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("no word moved for %0d cycles", QUIET_LIMIT);
            $display("simulation failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic offer_word(input action_t act, input target_t tgt, input logic lvl);
        if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            s_tdata  <= 8'($urandom);
            s_tuser  <= 3'($urandom);
            do @(posedge aclk); while ($urandom_range(99) < send_idle_pct);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b00000, lvl, tgt};
        s_tuser  <= act;
        do @(posedge aclk); while (!s_tready);
        words_sent++;
    endtask

    // Sample at the falling edge so the checker has settled for this cycle.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(negedge aclk); while (results_due != 0);
        @(posedge aclk);
    endtask

    task automatic write_reg(input int idx, input cnt_t val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(idx * 4);
        pwdata  <= {16'($urandom), val};
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic cnt_t timeout_for(input int round, input reg_idx_t idx);
        case (round)
            0: return '0;
            1: return '1;
            2: begin
                case (idx)
                    REG_ASCEND:   return RST_ASCEND;
                    REG_BURNWIRE: return RST_BURNWIRE;
                    REG_INFLATE:  return RST_INFLATE;
                    REG_CURE:     return RST_CURE;
                    REG_EQUALIZE: return RST_EQUALIZE;
                    default:      return RST_ANNOUNCE;
                endcase
            end
            default: begin
                if ($urandom_range(9) < 8) return cnt_t'($urandom_range(5));
                return cnt_t'($urandom_range(12, 6));
            end
        endcase
    endfunction

    // Mostly ticks so that flights run their course, with replies, manual
    // writes, relaunches and unused codes mixed in.
    task automatic random_word();
        int      r;
        action_t act;
        target_t tgt;
        logic    lvl;
        r   = $urandom_range(99);
        tgt = target_t'($urandom_range(3));
        lvl = 1'($urandom_range(1));
        if (r < 62) act = ACT_TICK;
        else if (r < 70) act = ACT_ACCEPT;
        else if (r < 75) act = ACT_CANCEL;
        else if (r < 86) act = ACT_MANUAL;
        else if (r < 89) act = action_t'($urandom_range({ACT_W{1'b1}}, ACT_MANUAL + 1));
        else if (r < 93) act = ACT_LAUNCH;
        else act = ACT_TICK;
        offer_word(act, tgt, lvl);
    endtask

    initial begin : stimulus
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // idle preflight: replies, manual writes, unused codes
        offer_word(ACT_TICK, TGT_TANK, 1'b0);
        offer_word(ACT_ACCEPT, TGT_TANK, 1'b0);
        offer_word(ACT_CANCEL, TGT_TANK, 1'b0);
        offer_word(ACT_MANUAL, TGT_TANK, 1'b1);
        offer_word(ACT_MANUAL, TGT_OUTLET, 1'b1);
        offer_word(ACT_MANUAL, TGT_BURN, 1'b1);
        offer_word(ACT_MANUAL, target_t'(TGT_BURN + 1), 1'b1);
        offer_word(ACT_MANUAL + 3'd1, target_t'(TGT_BURN + 1), 1'b1);
        offer_word(ACT_MANUAL + 3'd2, TGT_OUTLET, 1'b0);
        offer_word(ACT_MANUAL + 3'd3, target_t'(TGT_BURN + 1), 1'b1);
        offer_word(ACT_MANUAL, TGT_TANK, 1'b0);
        offer_word(ACT_MANUAL, TGT_OUTLET, 1'b0);
        offer_word(ACT_MANUAL, TGT_BURN, 1'b0);

        // short flight; cure and announce equal so both run out on one tick
        drain();
        write_reg(REG_ASCEND, 16'd0);
        write_reg(REG_BURNWIRE, 16'd1);
        write_reg(REG_INFLATE, 16'd2);
        write_reg(REG_CURE, 16'd2);
        write_reg(REG_EQUALIZE, 16'd1);
        write_reg(REG_ANNOUNCE, 16'd2);
        settings_used++;
        offer_word(ACT_LAUNCH, TGT_TANK, 1'b0);
        offer_word(ACT_LAUNCH, TGT_TANK, 1'b0);
        offer_word(ACT_TICK, TGT_TANK, 1'b0);
        offer_word(ACT_CANCEL, TGT_TANK, 1'b0);
        offer_word(ACT_ACCEPT, TGT_TANK, 1'b0);
        offer_word(ACT_TICK, TGT_TANK, 1'b0);
        offer_word(ACT_TICK, TGT_TANK, 1'b0);
        offer_word(ACT_TICK, TGT_TANK, 1'b0);
        offer_word(ACT_TICK, TGT_TANK, 1'b0);
        offer_word(ACT_TICK, TGT_TANK, 1'b0);
        offer_word(ACT_TICK, TGT_TANK, 1'b0);
        offer_word(ACT_LAUNCH, TGT_TANK, 1'b0);

        for (int round = 0; round < 8; round++) begin
            drain();
            for (int i = REG_ASCEND; i <= REG_ANNOUNCE; i++) begin
                write_reg(i, timeout_for(round, reg_idx_t'(i)));
            end
            if (round == 5) begin
                // writes beyond the register map must change nothing
                write_reg(REG_ANNOUNCE + 1, 16'($urandom));
                write_reg(REG_ANNOUNCE + 2, 16'($urandom));
            end
            settings_used++;
            case (round % 4)
                0: begin
                    send_idle_pct = 0;
                    stall_pct     = 0;
                end
                1: begin
                    send_idle_pct = 69;
                    stall_pct     = 0;
                end
                2: begin
                    send_idle_pct = 0;
                    stall_pct     = 69;
                end
                default: begin
                    send_idle_pct = 31;
                    stall_pct     = 31;
                end
            endcase
            // back up the pipeline while the sender keeps offering
            if (round == 4) hold_asks++;
            repeat ((round == 1) ? 60 : 175) random_word();
        end

        drain();
        repeat (8) @(posedge aclk);
        $display("%0d event words sent over %0d timeout settings, idle-free and with idling on",
                 words_sent, settings_used);
        $display("either side; %0d result words compared, one long receiver hold-off",
                 results_seen);
        if (mismatches == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule

[flight_phase_sequencer_core.f]
+incdir+design
design/fps_pkg.sv
design/fps_apb_regs.sv
design/fps_seq_state.sv
design/flight_phase_sequencer_core.sv
tb/fps_result_check.sv
tb/tb.sv
